// ===== rtl/core/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 message hasher.
// No dependencies; imported by sha256_comp, sha256_message_hasher and the testbench.
package sha256_pkg;

    localparam int WORD_W   = 32;
    localparam int HASH_N   = 8;
    localparam int BLOCK_W  = 512;
    localparam int ROUNDS_N = 64;

    localparam logic [5:0] FILL_LAST  = 6'd63;   // last byte slot of a block
    localparam logic [5:0] LEN_OFFSET = 6'd56;   // first byte of the bit length
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_hash [HASH_N];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } t_pad_phase;

    typedef struct packed {
        logic load;   // copy the chaining words into the working variables
        logic step;   // run one round
    } t_comp_ctl;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word v;
        unique case (idx)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
            default: v = 32'h428a2f98;
        endcase
        return v;
    endfunction

    // Message schedule sigmas
    function automatic t_word sched_s0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word sched_s1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Compression sigmas
    function automatic t_word round_s0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word round_s1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

// ===== rtl/core/sha256_comp.sv =====
// SHA-256 compression unit: eight working variables and one round per step.
// Depends on sha256_pkg.
module sha256_comp
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  t_comp_ctl i_ctl,
    input  logic [5:0] i_round,
    input  t_word     i_w,
    input  t_hash     i_chain,
    output t_hash     o_work
);

    t_hash r_work;
    t_hash n_work;
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    always_comb begin
        ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
        t1  = r_work[7] + round_s1(r_work[4]) + ch + round_k(i_round) + i_w;
        t2  = round_s0(r_work[0]) + maj;
        n_work = r_work;
        if (i_ctl.load) begin
            n_work = i_chain;
        end else if (i_ctl.step) begin
            n_work[7] = r_work[6];
            n_work[6] = r_work[5];
            n_work[5] = r_work[4];
            n_work[4] = r_work[3] + t1;
            n_work[3] = r_work[2];
            n_work[2] = r_work[1];
            n_work[1] = r_work[0];
            n_work[0] = t1 + t2;
        end
    end

    // Payload only; no reset needed
    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_work = r_work;

endmodule

// ===== rtl/core/sha256_message_hasher.sv =====
// SHA-256 message hasher top level: byte collection, padding, sequencing, digest output.
// Depends on sha256_pkg and sha256_comp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) moves one message byte per transfer,
//   with i_last_byte marking the end of a message and i_no_data marking a
//   transfer that carries no byte (only the end mark, or nothing at all).
//   Output channel (o_out_valid / i_out_ready) moves eight digest words per
//   message, index 0 first, o_last_word set on index 7.
// Timing:
//   Bytes are taken while the block is filling. The transfer that completes a
//   64-byte block starts the compression: the rounds in the one shared round
//   unit, then the fold into the chaining words, during which o_in_ready is
//   low. On the end mark the block appends padding (the 0x80 mark, zeros to
//   offset 56, the 8-byte bit length) at one byte per cycle while no block is
//   being compressed, compresses the last one or two blocks, then presents
//   the digest.
// Reset:
//   Synchronous, active low: chaining words return to the initial hash, fill and
//   byte counts clear, and the block comes up ready for a new message.
// Stall:
//   A digest word holds on the outputs until it is transferred; no new input is
//   taken before the eighth word is gone.
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_no_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state,   n_state;
    t_pad_phase  r_phase,   n_phase;
    logic [5:0]  r_fill,    n_fill;
    logic [60:0] r_count,   n_count;
    logic [63:0] r_len,     n_len;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic [5:0]  r_rnd,     n_rnd;
    logic [2:0]  r_widx,    n_widx;
    t_hash       r_chain,   n_chain;
    logic [BLOCK_W-1:0] r_win, n_win;

    logic       in_xfer;
    logic       out_xfer;
    logic       push_en;
    logic [7:0] push_byte;
    t_comp_ctl  comp_ctl;
    t_hash      work;
    t_word      w_cur;
    t_word      w_new;

    // Word j of the 16-word window, word 0 at the top
    function automatic t_word win_word(input logic [BLOCK_W-1:0] win, input int j);
        return win[BLOCK_W-1-WORD_W*j -: WORD_W];
    endfunction

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    assign w_cur = win_word(r_win, 0);
    assign w_new = sched_s1(win_word(r_win, 14)) + win_word(r_win, 9)
                 + sched_s0(win_word(r_win, 1)) + w_cur;

    sha256_comp u_comp (
        .i_clk   (i_clk),
        .i_ctl   (comp_ctl),
        .i_round (r_rnd),
        .i_w     (w_cur),
        .i_chain (r_chain),
        .o_work  (work)
    );

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_fill    = r_fill;
        n_count   = r_count;
        n_len     = r_len;
        n_len_cnt = r_len_cnt;
        n_rnd     = r_rnd;
        n_widx    = r_widx;
        n_chain   = r_chain;
        n_win     = r_win;
        push_en   = 1'b0;
        push_byte = PAD_ZERO;
        comp_ctl  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    push_en   = !i_no_data;
                    push_byte = i_data_byte;
                    n_count   = r_count + {60'd0, !i_no_data};
                    if (i_last_byte) begin
                        // capture the bit length, restart the count for the next message
                        n_len   = {n_count, 3'b000};
                        n_count = '0;
                        n_phase = PH_MARK;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                unique case (r_phase)
                    PH_MARK: begin
                        push_en   = 1'b1;
                        push_byte = PAD_MARK;
                        n_phase   = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_fill == LEN_OFFSET) begin
                            n_phase = PH_LEN;
                        end else begin
                            push_en = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        push_en   = 1'b1;
                        push_byte = r_len[63:56];
                        n_len     = {r_len[55:0], 8'h00};
                        n_len_cnt = r_len_cnt + 3'd1;
                        if (r_len_cnt == 3'd7) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_ROUND: begin
                comp_ctl.step = 1'b1;
                n_win = {r_win[BLOCK_W-WORD_W-1:0], w_new};
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'(ROUNDS_N - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < HASH_N; i++) begin
                    n_chain[i] = r_chain[i] + work[i];
                end
                priority case (r_phase)
                    PH_DONE: n_state = ST_EMIT;
                    PH_NONE: n_state = ST_IDLE;
                    default: n_state = ST_PAD;
                endcase
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    // rotate the chain, refilling with the initial hash behind
                    for (int i = 0; i < HASH_N - 1; i++) begin
                        n_chain[i] = r_chain[i+1];
                    end
                    n_chain[HASH_N-1] = init_hash(r_widx);
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        n_phase = PH_NONE;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Shift one byte into the window; start compression when the block is full
        if (push_en) begin
            n_win  = {r_win[BLOCK_W-9:0], push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == FILL_LAST) begin
                comp_ctl.load = 1'b1;
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_NONE;
            r_fill    <= '0;
            r_count   <= '0;
            r_len_cnt <= '0;
            r_rnd     <= '0;
            r_widx    <= '0;
            for (int i = 0; i < HASH_N; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_count   <= n_count;
            r_len_cnt <= n_len_cnt;
            r_rnd     <= n_rnd;
            r_widx    <= n_widx;
            r_chain   <= n_chain;
        end
    end

    // Window and length shifter hold payload only
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_len <= n_len;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = (r_state == ST_EMIT);
    assign o_digest_word = r_chain[0];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 3'd7);

endmodule

// ===== rtl/core/sha256_chk.sv =====
// Port-level checker for the SHA-256 message hasher, bound to the top level.
// Depends only on the ports of sha256_message_hasher.
module sha256_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_last_byte,
    input logic        i_no_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // Hold a stalled digest word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("digest word changed while stalled");

    // Never take input while a digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest pending");

    // Digest starts at word 0 and advances by one per transfer
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_word_index == 3'd0)
        else $error("digest did not start at word 0");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
            o_out_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest words not consecutive");

    // Return to ready after the last word
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_word |=> o_in_ready && !o_out_valid)
        else $error("not ready after last digest word");

endmodule

bind sha256_message_hasher sha256_chk u_chk (.*);

// ===== tb/tb_sha256_message_hasher.sv =====
// Self-checking testbench for sha256_message_hasher: directed rows, then random messages.
// Depends on sha256_pkg and the hasher RTL; carries its own SHA-256 predictor.
`timescale 1ns / 100ps

module tb_sha256_message_hasher;
    import sha256_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int ITEM_TARGET  = 310;
    localparam int DRAIN_CYCLES = 300;

    // Well-known digests of the empty message and of "abc"
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam t_word H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One digest word as it should leave the output channel
    typedef struct {
        t_word      word;
        logic [2:0] idx;
        logic       tail;
    } t_digest_beat;

    // One row of the directed table; has_gold marks a digest typed in by hand
    typedef struct packed {
        logic         has_gold;
        logic [255:0] gold;
        logic [7:0]   octet;
        logic         mark;
        logic         nobyte;
    } t_feed_row;

    localparam int ROW_N = 17;
    localparam t_feed_row DIRECTED_ROWS [ROW_N] = '{
        '{1'b1, EMPTY_DIGEST, 8'h00, 1'b1, 1'b1},  // empty message straight after reset
        '{1'b0, 256'd0,       8'hff, 1'b0, 1'b1},  // no byte, no end mark: ignored
        '{1'b1, EMPTY_DIGEST, 8'ha5, 1'b1, 1'b1},  // empty again, data must be ignored
        '{1'b0, 256'd0,       8'h61, 1'b0, 1'b0},
        '{1'b0, 256'd0,       8'h62, 1'b0, 1'b0},
        '{1'b1, ABC_DIGEST,   8'h63, 1'b1, 1'b0},  // "abc", end mark on the byte
        '{1'b0, 256'd0,       8'h00, 1'b0, 1'b0},
        '{1'b0, 256'd0,       8'hff, 1'b0, 1'b0},
        '{1'b0, 256'd0,       8'h55, 1'b0, 1'b0},
        '{1'b0, 256'd0,       8'haa, 1'b0, 1'b0},
        '{1'b0, 256'd0,       8'hff, 1'b0, 1'b1},  // ignored in the middle of a message
        '{1'b0, 256'd0,       8'h3c, 1'b1, 1'b1},  // end mark without a byte
        '{1'b0, 256'd0,       8'hff, 1'b1, 1'b0},  // single-byte messages follow, then a two-byte one
        '{1'b0, 256'd0,       8'h80, 1'b1, 1'b0},
        '{1'b0, 256'd0,       8'h00, 1'b1, 1'b0},
        '{1'b0, 256'd0,       8'h7f, 1'b0, 1'b0},
        '{1'b0, 256'd0,       8'h01, 1'b1, 1'b0}
    };

    localparam int EDGE_N = 6;
    localparam int EDGE_LENGTHS [EDGE_N] = '{55, 56, 57, 63, 64, 65};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        i_no_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_message_hasher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_no_data     (i_no_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: chaining words, partial block, fill level, message length
    t_word       chain_words [8];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [60:0] msg_bytes;

    t_digest_beat digest_due [$];
    int           mismatches = 0;
    int unsigned  items_sent = 0;
    int unsigned  burst_left = 0;
    bit           steady = 1'b0;

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic predictor_clear();
        for (int i = 0; i < 8; i++) chain_words[i] = H_START[i];
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        block_fill = 0;
        msg_bytes  = '0;
    endtask

    // Run the 64 rounds on the gathered block and fold into the chaining words
    task automatic compress_block();
        t_word sched [64];
        t_word v [8];
        t_word s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain_words[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + sched[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // Update the predictor with one accepted transfer; queue the digest on an end mark
    task automatic hash_transfer(input logic [7:0] octet, input logic mark,
                                 input logic nobyte);
        t_digest_beat beat;
        logic [63:0]  bit_len;
        if (!nobyte) begin
            msg_bytes++;
            absorb_byte(octet);
        end
        if (mark) begin
            bit_len = {msg_bytes, 3'b000};
            absorb_byte(8'h80);
            while (block_fill != 56) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                beat.word = chain_words[i];
                beat.idx  = 3'(i);
                beat.tail = (i == 7);
                digest_due.push_back(beat);
            end
            predictor_clear();
        end
    endtask

    // Present one item, hold it until the transfer, then predict
    task automatic send_item(input logic [7:0] octet, input logic mark, input logic nobyte);
        i_in_valid  <= 1'b1;
        i_data_byte <= octet;
        i_last_byte <= mark;
        i_no_data   <= nobyte;
        do @(posedge i_clk); while (!o_in_ready);
        hash_transfer(octet, mark, nobyte);
        items_sent++;
    endtask

    // Sender bursts unless steady is set: drop valid for a random gap when the burst runs out
    task automatic pace();
        int unsigned gap;
        if (steady) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 6);
        i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        burst_left = $urandom_range(0, 15);
    endtask

    // Hold the input side until every queued digest word has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (digest_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 8);
            5, 6:          return $urandom_range(9, 40);
            7, 8:          return EDGE_LENGTHS[$urandom_range(0, EDGE_N - 1)];
            default:       return $urandom_range(110, 130);
        endcase
    endfunction

    // Output side: check each transfer, stall according to a randomly picked stall mode
    int unsigned  cycle_count = 0;
    int unsigned  stall_mode  = 0;
    t_digest_beat want;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_due.size() == 0) begin
                mismatches++;
                $display("%0t: digest word with nothing expected: %h idx %0d", $time,
                         o_digest_word, o_word_index);
            end else begin
                want = digest_due.pop_front();
                if (o_digest_word !== want.word) begin
                    mismatches++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.word, o_digest_word);
                end
                if (o_word_index !== want.idx) begin
                    mismatches++;
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.idx, o_word_index);
                end
                if (o_last_word !== want.tail) begin
                    mismatches++;
                    $display("%0t: last_word expected %b actual %b", $time,
                             want.tail, o_last_word);
                end
            end
        end
        if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= (cycle_count % 4 == 0);
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sha256_message_hasher] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned msg_len;
        int unsigned msg_count;
        bit          end_apart;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        i_no_data   <= 1'b0;
        predictor_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; a typed-in digest replaces the predicted words
        for (int r = 0; r < ROW_N; r++) begin
            send_item(DIRECTED_ROWS[r].octet, DIRECTED_ROWS[r].mark, DIRECTED_ROWS[r].nobyte);
            if (DIRECTED_ROWS[r].has_gold)
                for (int k = 0; k < 8; k++)
                    digest_due[digest_due.size() - 8 + k].word =
                        DIRECTED_ROWS[r].gold[255 - 32*k -: 32];
            pace();
        end
        drain();

        // Random messages: mostly short, some around the padding and block boundaries
        msg_count = 0;
        while (items_sent < ITEM_TARGET) begin
            msg_len   = pick_length();
            end_apart = (msg_len == 0) || ($urandom_range(0, 3) == 0);
            steady    = ($urandom_range(0, 3) == 0);
            for (int unsigned n = 0; n < msg_len; n++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    pace();
                end
                send_item(8'($urandom_range(0, 255)), !end_apart && (n == msg_len - 1),
                          1'b0);
                pace();
            end
            if (end_apart) begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                pace();
            end
            msg_count++;
            if (msg_count == 5) drain();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[sha256_message_hasher] OK");
        end else begin
            $display("[sha256_message_hasher] ERROR");
        end
        $finish;
    end

endmodule
